// ----- hw/rtl/key_event_detector_macros.svh -----
// Assertion macros for the key event detector
`ifndef KEY_EVENT_DETECTOR_MACROS_SVH
`define KEY_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define KED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define KED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ked_pkg.sv -----
// Package: constants, event codes and types of the key event detector
package ked_pkg;

    localparam int NUM_KEYS   = 16;
    localparam int KEY_ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_W      = 4;
    localparam int TIME_W     = 16;
    localparam int TMR_W      = 17;
    localparam int PRESS_W    = 32;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 2;
    localparam int MAX_EVENTS = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DCLICK_WIN   = 3'd4;

    localparam logic [TIME_W-1:0] RST_DEBOUNCE     = 16'd20;
    localparam logic [TIME_W-1:0] RST_LONG_PRESS   = 16'd1000;
    localparam logic [TIME_W-1:0] RST_REPEAT_START = 16'd500;
    localparam logic [TIME_W-1:0] RST_REPEAT_PER   = 16'd100;
    localparam logic [TIME_W-1:0] RST_DCLICK_WIN   = 16'd300;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code EV_PRESS        = 3'd0;
    localparam t_code EV_RELEASE      = 3'd1;
    localparam t_code EV_LONG_RELEASE = 3'd2;
    localparam t_code EV_DOUBLE       = 3'd3;
    localparam t_code EV_LONG         = 3'd4;
    localparam t_code EV_REPEAT       = 3'd5;
    localparam t_code EV_CLICK        = 3'd6;

    typedef struct packed {
        logic               last_raw;
        logic               stable_pressed;
        logic               long_reported;
        logic               click_pending;
        logic [TMR_W-1:0]   debounce_timer;
        logic [PRESS_W-1:0] press_timer;
        logic [TMR_W-1:0]   repeat_timer;
        logic [TMR_W-1:0]   click_wait_timer;
    } t_key_state;

    typedef struct packed {
        logic [KEY_W-1:0]                 key;
        logic [CNT_W-1:0]                 cnt;
        logic [MAX_EVENTS-1:0][CODE_W-1:0] codes;
    } t_result;

endpackage

// ----- hw/rtl/key_event_detector.sv -----
// Key event detector: per-key debounce; press, release, click, double, long, long-release, repeat events
//
// Input channel (i_in_valid / o_in_stall): one sample of one key per transaction,
// with key index, raw level and milliseconds since the previous poll. A sample with
// zero elapsed time or an out-of-range key is taken and dropped.
// Output channel (o_out_valid / i_out_stall): one event per transaction, with key,
// code and a flag on the last event caused by a sample; a sample yields 0 to 3.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at a clock edge.
// Per-key state sits in a 16-entry memory with a registered read; each
// sample reads its entry as it is taken, updates it in the next cycle and writes it
// back, with the previous sample's result forwarded when both name the same key.
// Throughput: one sample per cycle while o_in_stall is low and one event per cycle
// while i_out_stall is low; the output side sets the sustained rate when samples
// cause more than one event.
// Events queue in a four-entry result buffer; o_in_stall rises when it could not
// take another sample's events, so a stalled receiver backs up to the input.
// Reset marks every entry invalid so that it reads as zero, restores the register
// defaults and empties the buffer; no clearing pass is needed.
module key_event_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ked_pkg::KEY_W-1:0]       i_key_index,
    input  logic                            i_raw_pressed,
    input  logic [ked_pkg::TIME_W-1:0]      i_elapsed_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ked_pkg::KEY_W-1:0]       o_event_key,
    output logic [ked_pkg::CODE_W-1:0]      o_event_code,
    output logic                            o_last_event,
    input  logic                            i_cfg_we,
    input  logic [ked_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ked_pkg::TIME_W-1:0]      i_cfg_data
);
    import ked_pkg::*;

    `include "key_event_detector_macros.svh"

    logic [TIME_W-1:0] r_debounce_time;
    logic [TIME_W-1:0] r_long_press_time;
    logic [TIME_W-1:0] r_repeat_start_time;
    logic [TIME_W-1:0] r_repeat_period;
    logic [TIME_W-1:0] r_dclick_window;

    t_key_state        r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_vld;

    logic              r_s1_valid;
    logic [KEY_W-1:0]  r_s1_key;
    logic              r_s1_raw;
    logic [TIME_W-1:0] r_s1_dt;
    t_key_state        r_rd_state;
    logic              r_rd_vld;
    logic              r_fwd_hit;
    t_key_state        r_fwd_state;

    t_result           r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]  r_fifo_cnt;
    logic [CNT_W-1:0]  r_sub;

    logic              in_accept;
    logic              in_keep;
    logic [KEY_ADDR_W-1:0] in_addr;
    logic [KEY_ADDR_W-1:0] s1_addr;
    logic              out_accept;
    logic              pop;
    logic              push;
    t_result           head;

    t_key_state        cur;
    t_key_state        n_state;
    logic [CNT_W-1:0]  n_cnt;
    logic [MAX_EVENTS:0][CODE_W-1:0] n_codes;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time     <= RST_DEBOUNCE;
            r_long_press_time   <= RST_LONG_PRESS;
            r_repeat_start_time <= RST_REPEAT_START;
            r_repeat_period     <= RST_REPEAT_PER;
            r_dclick_window     <= RST_DCLICK_WIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:     r_debounce_time     <= i_cfg_data;
                CFG_LONG_PRESS:   r_long_press_time   <= i_cfg_data;
                CFG_REPEAT_START: r_repeat_start_time <= i_cfg_data;
                CFG_REPEAT_PER:   r_repeat_period     <= i_cfg_data;
                CFG_DCLICK_WIN:   r_dclick_window     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = ({1'b0, r_fifo_cnt} + {{FIFO_AW{1'b0}}, 1'b0, r_s1_valid})
                        >= (FIFO_AW + 2)'(FIFO_DEPTH);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_keep    = in_accept && (i_elapsed_ms != '0)
                        && (32'(i_key_index) < 32'(NUM_KEYS));
    assign in_addr    = i_key_index[KEY_ADDR_W-1:0];
    assign s1_addr    = r_s1_key[KEY_ADDR_W-1:0];

    // State memory: read on each kept transaction, write back from the update stage
    always_ff @(posedge i_clk) begin
        if (in_keep) begin
            r_rd_state <= r_mem[in_addr];
        end
        if (r_s1_valid) begin
            r_mem[s1_addr] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_keep) begin
            r_s1_key    <= i_key_index;
            r_s1_raw    <= i_raw_pressed;
            r_s1_dt     <= i_elapsed_ms;
            r_rd_vld    <= r_vld[in_addr];
            r_fwd_hit   <= r_s1_valid && (s1_addr == in_addr);
            r_fwd_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_keep;
            if (r_s1_valid) begin
                r_vld[s1_addr] <= 1'b1;
            end
        end
    end

    // Update stage
    always_comb begin
        logic [TMR_W-1:0]   db1;
        logic               trans;
        logic [PRESS_W:0]   psum;
        logic [TMR_W-1:0]   rsum;
        logic [TMR_W-1:0]   csum;
        logic [TMR_W-1:0]   dt17;

        if (r_fwd_hit) begin
            cur = r_fwd_state;
        end else if (r_rd_vld) begin
            cur = r_rd_state;
        end else begin
            cur = '0;
        end

        dt17    = TMR_W'(r_s1_dt);
        n_state = cur;
        n_cnt   = '0;
        n_codes = '0;

        n_state.last_raw = r_s1_raw;
        if (r_s1_raw != cur.last_raw) begin
            db1 = '0;
        end else if (cur.debounce_timer < TMR_W'(r_debounce_time)) begin
            db1 = cur.debounce_timer + dt17;
        end else begin
            db1 = cur.debounce_timer;
        end
        n_state.debounce_timer = db1;

        trans = (db1 >= TMR_W'(r_debounce_time)) && (cur.stable_pressed != r_s1_raw);

        if (trans) begin
            n_state.stable_pressed = r_s1_raw;
            n_state.press_timer    = '0;
            n_state.repeat_timer   = '0;
            n_state.long_reported  = 1'b0;
            n_codes[n_cnt] = r_s1_raw ? EV_PRESS : EV_RELEASE;
            n_cnt = n_cnt + 1'b1;
            if (!r_s1_raw) begin
                n_state.click_wait_timer = '0;
                if (cur.long_reported) begin
                    n_codes[n_cnt] = EV_LONG_RELEASE;
                    n_cnt = n_cnt + 1'b1;
                    n_state.click_pending = 1'b0;
                end else if (cur.click_pending
                             && (cur.click_wait_timer <= TMR_W'(r_dclick_window))) begin
                    n_codes[n_cnt] = EV_DOUBLE;
                    n_cnt = n_cnt + 1'b1;
                    n_state.click_pending = 1'b0;
                end else begin
                    n_state.click_pending = 1'b1;
                end
            end
        end

        psum = {1'b0, n_state.press_timer} + (PRESS_W + 1)'(r_s1_dt);
        rsum = n_state.repeat_timer + dt17;
        csum = n_state.click_wait_timer + dt17;

        if (n_state.stable_pressed) begin
            n_state.press_timer = psum[PRESS_W] ? '1 : psum[PRESS_W-1:0];
            if (!n_state.long_reported
                && (n_state.press_timer >= PRESS_W'(r_long_press_time))) begin
                n_state.long_reported = 1'b1;
                n_codes[n_cnt] = EV_LONG;
                n_cnt = n_cnt + 1'b1;
            end
            if (n_state.press_timer >= PRESS_W'(r_repeat_start_time)) begin
                if (rsum >= TMR_W'(r_repeat_period)) begin
                    n_state.repeat_timer = '0;
                    n_codes[n_cnt] = EV_REPEAT;
                    n_cnt = n_cnt + 1'b1;
                end else begin
                    n_state.repeat_timer = rsum;
                end
            end
        end else if (n_state.click_pending) begin
            if (csum >= TMR_W'(r_dclick_window)) begin
                n_state.click_pending    = 1'b0;
                n_state.click_wait_timer = '0;
                n_codes[n_cnt] = EV_CLICK;
                n_cnt = n_cnt + 1'b1;
            end else begin
                n_state.click_wait_timer = csum;
            end
        end
    end

    // Result buffer and event serialiser
    assign push        = r_s1_valid && (n_cnt != '0);
    assign head        = r_fifo[r_rd_ptr];
    assign o_out_valid = (r_fifo_cnt != '0);
    assign o_event_key = head.key;
    assign o_event_code = head.codes[r_sub];
    assign o_last_event = (r_sub == (head.cnt - 1'b1));
    assign out_accept  = o_out_valid && !i_out_stall;
    assign pop         = out_accept && o_last_event;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{key: r_s1_key, cnt: n_cnt,
                                  codes: n_codes[MAX_EVENTS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_sub      <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_sub    <= '0;
            end else if (out_accept) begin
                r_sub <= r_sub + 1'b1;
            end
            if (push && !pop) begin
                r_fifo_cnt <= r_fifo_cnt + 1'b1;
            end else if (pop && !push) begin
                r_fifo_cnt <= r_fifo_cnt - 1'b1;
            end
        end
    end

    `KED_ASSERT_IMP(a_no_overflow, push && !pop, r_fifo_cnt < (FIFO_AW + 1)'(FIFO_DEPTH), "result buffer overflow")
    `KED_ASSERT_IMP(a_sub_in_range, o_out_valid, (r_sub < head.cnt) && (head.cnt != '0), "event index beyond entry count")
    `KED_ASSERT_NXT(a_last_restarts, pop, r_sub == '0, "event index not restarted after last event")
    `KED_ASSERT_IMP(a_full_stalls, r_fifo_cnt == (FIFO_AW + 1)'(FIFO_DEPTH), o_in_stall, "input taken with full result buffer")

endmodule
